// ----- hw/rtl/bpd_pkg.sv -----
// Shared constants and status codes of the byte pair decoder.
`default_nettype none

package bpd_pkg;

    localparam int unsigned DEF_MAX_PAIRS = 127;
    localparam int unsigned DEF_MAX_RUN   = 64;

    localparam logic [7:0] DELIM    = 8'hFF;
    localparam logic [7:0] SYM_BASE = 8'h80;

    // Symbol index and pair count share the 7 low bits of a byte.
    localparam int unsigned IDX_W = 7;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_NODELIM = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/byte_pair_decoder_core.sv -----
// Byte pair decoder top level: header table build and stack-based symbol expansion.
//
// Takes a compressed file one byte per request. Header bytes before the first
// 0xFF fill the pair table (pair i defines symbol 0x80+i); later bytes are
// literals or symbols, which expand depth-first through a stack memory. A
// data byte is accepted and then expanded step by step: a plain byte on top is
// emitted, after which the next stack entry is popped unless the run ends; a
// symbol on top reads the table, then pushes its second byte while its first
// byte becomes the new top. Output stalls hold the expansion. The table and
// stack memories are single-port with registered reads. An expansion longer
// than MAX_RUN bytes stops after MAX_RUN bytes with status 1 on its last
// byte. End of file before any delimiter gives one result with status 2. End
// of file returns the block to its reset state once the byte is done. No
// clearing pass is needed.
`default_nettype none

module byte_pair_decoder_core #(
    parameter int unsigned MAX_PAIRS = bpd_pkg::DEF_MAX_PAIRS,
    parameter int unsigned MAX_RUN   = bpd_pkg::DEF_MAX_RUN
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,   // end_of_file
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast,   // run_last
    output logic [1:0]      o_m_axis_tuser    // [1:0] status
);

    localparam int unsigned IW  = bpd_pkg::IDX_W;
    localparam int unsigned TAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int unsigned SPW = $clog2(MAX_PAIRS + 1);
    localparam int unsigned RW  = $clog2(MAX_RUN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOS,
        S_TBL,
        S_POP
    } t_state;

    // Entry is {expand flag, byte}; symbols expand only below the given limit.
    function automatic logic [8:0] make_entry(input logic [7:0] b, input logic [IW-1:0] lim);
        make_entry = {b[7] && (b[IW-1:0] < lim), b};
    endfunction

    t_state            r_state;
    logic              r_in_data;
    logic [IW-1:0]     r_pair_cnt;
    logic              r_half;
    logic [7:0]        r_held;
    logic              r_eof;
    logic [SPW-1:0]    r_depth;
    logic [RW-1:0]     r_run;
    logic [8:0]        r_tos;

    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_olast;
    bpd_pkg::t_status  r_ostatus;

    // Pair table and expansion stack memories.
    logic [15:0]     tbl_mem [MAX_PAIRS];
    logic [8:0]      stk_mem [MAX_PAIRS];
    logic [15:0]     r_tbl_rd;
    logic [8:0]      r_stk_rd;

    logic            out_free;
    logic            in_acc;
    logic            tbl_we;
    logic            tbl_re;
    logic            stk_we;
    logic            stk_re;
    logic [TAW-1:0]  stk_waddr;
    logic [TAW-1:0]  stk_raddr;
    logic [SPW-1:0]  depth_dec;
    logic            run_full;
    logic            emit_last;
    logic [8:0]      child_lo;
    logic [8:0]      child_hi;

    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ostatus;

    assign depth_dec = r_depth - SPW'(1);
    assign run_full  = (r_run == RW'(MAX_RUN - 1));
    assign emit_last = (r_depth == '0) || run_full;
    assign child_lo  = make_entry(r_tbl_rd[7:0], r_tos[IW-1:0]);
    assign child_hi  = make_entry(r_tbl_rd[15:8], r_tos[IW-1:0]);
    assign stk_waddr = r_depth[TAW-1:0];
    assign stk_raddr = depth_dec[TAW-1:0];

    always_comb begin
        tbl_we = in_acc && !r_in_data && (i_s_axis_tdata != bpd_pkg::DELIM) && r_half
                 && (r_pair_cnt < IW'(MAX_PAIRS));
        tbl_re = (r_state == S_TOS) && r_tos[8];
        stk_we = (r_state == S_TBL);
        stk_re = (r_state == S_TOS) && !r_tos[8] && out_free && !emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[r_pair_cnt[TAW-1:0]] <= {r_held, i_s_axis_tdata};
        end
        if (tbl_re) begin
            r_tbl_rd <= tbl_mem[r_tos[TAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= child_lo;
        end
        if (stk_re) begin
            r_stk_rd <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_data  <= 1'b0;
            r_pair_cnt <= '0;
            r_half     <= 1'b0;
            r_eof      <= 1'b0;
            r_depth    <= '0;
            r_run      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_in_data) begin
                            r_tos   <= make_entry(i_s_axis_tdata, r_pair_cnt);
                            r_depth <= '0;
                            r_run   <= '0;
                            r_eof   <= i_s_axis_tlast;
                            r_state <= S_TOS;
                        end else begin
                            priority if (i_s_axis_tdata == bpd_pkg::DELIM) begin
                                r_in_data <= 1'b1;
                                r_half    <= 1'b0;
                            end else if (r_half) begin
                                if (r_pair_cnt < IW'(MAX_PAIRS)) begin
                                    r_pair_cnt <= r_pair_cnt + IW'(1);
                                end
                                r_half <= 1'b0;
                            end else begin
                                r_held <= i_s_axis_tdata;
                                r_half <= 1'b1;
                            end
                            if (i_s_axis_tlast) begin
                                if (i_s_axis_tdata != bpd_pkg::DELIM) begin
                                    r_ovalid  <= 1'b1;
                                    r_obyte   <= 8'h00;
                                    r_olast   <= 1'b1;
                                    r_ostatus <= bpd_pkg::ST_NODELIM;
                                end
                                r_in_data  <= 1'b0;
                                r_pair_cnt <= '0;
                                r_half     <= 1'b0;
                            end
                        end
                    end
                end
                S_TOS: begin
                    if (r_tos[8]) begin
                        r_state <= S_TBL;
                    end else if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_obyte   <= r_tos[7:0];
                        r_olast   <= emit_last;
                        r_ostatus <= (run_full && (r_depth != '0)) ? bpd_pkg::ST_TRUNC
                                                                  : bpd_pkg::ST_DATA;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                            if (r_eof) begin
                                r_in_data  <= 1'b0;
                                r_pair_cnt <= '0;
                                r_half     <= 1'b0;
                            end
                        end else begin
                            r_depth <= depth_dec;
                            r_run   <= r_run + RW'(1);
                            r_state <= S_POP;
                        end
                    end
                end
                S_TBL: begin
                    // Second byte stays in memory, first byte becomes the new top.
                    r_depth <= r_depth + SPW'(1);
                    r_tos   <= child_hi;
                    r_state <= S_TOS;
                end
                S_POP: begin
                    r_tos   <= r_stk_rd;
                    r_state <= S_TOS;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bpd_checker.sv -----
// Port-level checks of the byte pair decoder and their binding to the top level.
`default_nettype none

module bpd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_axis_tready,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tlast,
    input wire logic [1:0] o_m_axis_tuser
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == bpd_pkg::ST_DATA)
                         || (o_m_axis_tuser == bpd_pkg::ST_TRUNC)
                         || (o_m_axis_tuser == bpd_pkg::ST_NODELIM))
        else $error("bpd: undefined status code");

    a_nodelim_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == bpd_pkg::ST_NODELIM))
        |-> (o_m_axis_tdata == 8'h00) && o_m_axis_tlast)
        else $error("bpd: missing-delimiter result malformed");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == bpd_pkg::ST_TRUNC)) |-> o_m_axis_tlast)
        else $error("bpd: truncation flagged before end of run");

    // a pending byte that is not the end of its run means the expansion is still busy
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("bpd: input taken in the middle of a run");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("bpd: stalled result changed");

endmodule

bind byte_pair_decoder_core bpd_checker u_bpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
